// ===== sv/pcm_frame_unpacker_defines.svh =====
// Assertion macros shared by the PCM frame unpacker RTL.
// Needs a clock and an active-low reset in scope where the short form is used.
`ifndef PCM_FRAME_UNPACKER_DEFINES_SVH
`define PCM_FRAME_UNPACKER_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PFU_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk_i and rst_ni.
`define PFU_ASSERT(label, prop, msg) `PFU_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/pfu_pkg.sv =====
// Package of the PCM frame unpacker: configuration, command and status types.
// Used by the register block, the controller, the datapath and the top level.
package pfu_pkg;

  localparam int unsigned DEF_MAX_CHANNELS     = 8;
  localparam int unsigned DEF_MAX_SAMPLE_BYTES = 4;

  localparam int unsigned CFG_AW = 5;   // byte address of the last register is 16
  localparam int unsigned SIZE_W = 7;   // frame size and byte address arithmetic

  typedef enum logic [2:0] {
    REG_SAMPLE_BYTES  = 3'd0,
    REG_CHANNEL_COUNT = 3'd1,
    REG_BIG_ENDIAN    = 3'd2,
    REG_FRAME_LIMIT   = 3'd3,
    REG_CHANNEL_ORDER = 3'd4
  } reg_idx_e;

  localparam logic [2:0]  RST_SAMPLE_BYTES  = 3'd2;
  localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd2;
  localparam logic        RST_BIG_ENDIAN    = 1'b0;
  localparam logic [31:0] RST_FRAME_LIMIT   = 32'd0;
  localparam logic [23:0] RST_CHANNEL_ORDER = 24'hFAC688;

  typedef struct packed {
    logic [2:0]  sample_bytes;
    logic [3:0]  channel_count;
    logic        big_endian;
    logic [31:0] frame_limit;
    logic [23:0] channel_order;
  } cfg_t;

  typedef struct packed {
    logic take_byte;
    logic start_frame;
    logic pick;
    logic fetch;
    logic load_zero;
    logic load_sample;
    logic next_chan;
  } cmd_t;

  typedef struct packed {
    logic blocked;
    logic frame_end;
    logic zero_pick;
    logic k_last;
    logic j_last;
  } status_t;

endpackage

// ===== sv/pfu_regs.sv =====
// Configuration registers of the PCM frame unpacker behind an APB-style port.
// Depends on pfu_pkg for the register indices, reset values and cfg_t.
module pfu_regs import pfu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_bytes  <= RST_SAMPLE_BYTES;
      cfg_q.channel_count <= RST_CHANNEL_COUNT;
      cfg_q.big_endian    <= RST_BIG_ENDIAN;
      cfg_q.frame_limit   <= RST_FRAME_LIMIT;
      cfg_q.channel_order <= RST_CHANNEL_ORDER;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SAMPLE_BYTES:  cfg_q.sample_bytes  <= pwdata[2:0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[3:0];
        REG_BIG_ENDIAN:    cfg_q.big_endian    <= pwdata[0];
        REG_FRAME_LIMIT:   cfg_q.frame_limit   <= pwdata;
        REG_CHANNEL_ORDER: cfg_q.channel_order <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SAMPLE_BYTES:  prdata = {29'd0, cfg_q.sample_bytes};
      REG_CHANNEL_COUNT: prdata = {28'd0, cfg_q.channel_count};
      REG_BIG_ENDIAN:    prdata = {31'd0, cfg_q.big_endian};
      REG_FRAME_LIMIT:   prdata = cfg_q.frame_limit;
      REG_CHANNEL_ORDER: prdata = {8'd0, cfg_q.channel_order};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/pfu_ctrl.sv =====
// Controller of the PCM frame unpacker: collects bytes, then sequences the results.
// Depends on pfu_pkg for cmd_t and status_t, and on the assertion macro header.
`include "pcm_frame_unpacker_defines.svh"
module pfu_ctrl import pfu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  output logic    m_tvalid_o,
  input  logic    m_tready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_COLLECT = 5'b00001,
    ST_PICK    = 5'b00010,
    ST_FETCH   = 5'b00100,
    ST_DRAIN   = 5'b01000,
    ST_SEND    = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    m_tvalid_o = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        s_tready_o = 1'b1;
        // Words that arrive once the frame limit is reached are taken and dropped.
        if (s_tvalid_i && !status_i.blocked) begin
          cmd_o.take_byte = 1'b1;
          if (status_i.frame_end) begin
            cmd_o.start_frame = 1'b1;
            state_d           = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        if (status_i.zero_pick) begin
          cmd_o.load_zero = 1'b1;
          state_d         = ST_SEND;
        end else begin
          cmd_o.pick = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        if (status_i.k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last byte read is merged on its way into the output register.
        cmd_o.load_sample = 1'b1;
        state_d           = ST_SEND;
      end
      ST_SEND: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          if (status_i.j_last) begin
            state_d = ST_COLLECT;
          end else begin
            cmd_o.next_chan = 1'b1;
            state_d         = ST_PICK;
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  `PFU_ASSERT(a_sides_apart, !(s_tready_o && m_tvalid_o), "input and output open together")
  `PFU_ASSERT(a_load_after_fetch, cmd_o.load_sample |-> $past(cmd_o.fetch), "load without read")
  `PFU_ASSERT(a_fetch_in_range, cmd_o.fetch |-> !status_i.zero_pick, "read for a zero sample")
  `PFU_ASSERT(a_last_fetch_loads, cmd_o.fetch && status_i.k_last |=> cmd_o.load_sample, "no load")

endmodule

// ===== sv/pfu_dp.sv =====
// Datapath of the PCM frame unpacker: frame byte store, counters, sample assembly
// and the output register. Depends on pfu_pkg for cfg_t, cmd_t and status_t.
module pfu_dp import pfu_pkg::*; #(
  parameter int unsigned MAX_CHANNELS     = DEF_MAX_CHANNELS,
  parameter int unsigned MAX_SAMPLE_BYTES = DEF_MAX_SAMPLE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic [7:0]  data_byte_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  output logic [2:0]  out_channel_o,
  output logic [31:0] sample_value_o,
  output logic        out_status_o,
  output logic        frame_last_o
);

  localparam int unsigned DEPTH  = MAX_CHANNELS * MAX_SAMPLE_BYTES;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [2:0]  MAX_NB = 3'(MAX_SAMPLE_BYTES);
  localparam logic [3:0]  MAX_NC = 4'(MAX_CHANNELS);

  logic [7:0]        mem_q [DEPTH];
  logic [7:0]        rd_data_q;
  logic              rd_vld_q;
  logic [1:0]        rd_k_q;
  logic [AW-1:0]     bp_q;
  logic [31:0]       frames_done_q;
  logic [2:0]        j_q;
  logic [1:0]        k_q;
  logic [31:0]       raw_q;
  logic [2:0]        nb;
  logic [3:0]        nc;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] bp_inc;
  logic [SIZE_W-1:0] rd_addr_full;
  logic [AW-1:0]     rd_addr;
  logic [2:0]        src;
  logic              unsupported;
  logic [31:0]       raw_next;
  logic [31:0]       norm;

  function automatic logic [31:0] merge_byte(input logic [31:0] raw, input logic [7:0] b,
                                             input logic [1:0] kk, input logic be);
    logic [31:0] res;
    if (be) begin
      res = {raw[23:0], b};
    end else begin
      res = raw | (32'(b) << {kk, 3'b000});
    end
    return res;
  endfunction

  // Out-of-range sizes are clamped to the nearest legal value.
  always_comb begin
    if (cfg_i.sample_bytes == 3'd0) begin
      nb = 3'd1;
    end else if (cfg_i.sample_bytes > MAX_NB) begin
      nb = MAX_NB;
    end else begin
      nb = cfg_i.sample_bytes;
    end
    if (cfg_i.channel_count == 4'd0) begin
      nc = 4'd1;
    end else if (cfg_i.channel_count > MAX_NC) begin
      nc = MAX_NC;
    end else begin
      nc = cfg_i.channel_count;
    end
  end

  assign size         = SIZE_W'(nb) * SIZE_W'(nc);
  assign bp_inc       = SIZE_W'(bp_q) + SIZE_W'(1);
  assign src          = cfg_i.channel_order[3*j_q +: 3];
  assign unsupported  = cfg_i.big_endian && (nb >= 3'd3);
  assign rd_addr_full = SIZE_W'(src) * SIZE_W'(nb) + SIZE_W'(k_q);
  assign rd_addr      = rd_addr_full[AW-1:0];

  assign status_o.blocked   = (cfg_i.frame_limit != 32'd0) &&
                              (frames_done_q >= cfg_i.frame_limit);
  assign status_o.frame_end = (bp_inc >= size);
  assign status_o.zero_pick = unsupported || ({1'b0, src} >= nc);
  assign status_o.k_last    = ({1'b0, k_q} == (nb - 3'd1));
  assign status_o.j_last    = ({1'b0, j_q} == (nc - 4'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_q          <= '0;
      frames_done_q <= 32'd0;
      j_q           <= 3'd0;
      k_q           <= 2'd0;
      rd_vld_q      <= 1'b0;
      rd_k_q        <= 2'd0;
    end else begin
      if (cmd_i.take_byte) begin
        if (status_o.frame_end) begin
          bp_q <= '0;
          if (cfg_i.frame_limit != 32'd0) begin
            frames_done_q <= frames_done_q + 32'd1;
          end
        end else begin
          bp_q <= bp_inc[AW-1:0];
        end
      end
      if (cmd_i.start_frame) begin
        j_q <= 3'd0;
      end else if (cmd_i.next_chan) begin
        j_q <= j_q + 3'd1;
      end
      if (cmd_i.pick) begin
        k_q <= 2'd0;
      end else if (cmd_i.fetch) begin
        k_q <= k_q + 2'd1;
      end
      rd_vld_q <= cmd_i.fetch;
      rd_k_q   <= k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      mem_q[bp_q] <= data_byte_i;
    end
    if (cmd_i.fetch) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Each read byte lands in the cycle after its address and is merged then.
  assign raw_next = merge_byte(raw_q, rd_data_q, rd_k_q, cfg_i.big_endian);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      raw_q <= 32'd0;
    end else if (rd_vld_q) begin
      raw_q <= raw_next;
    end
  end

  // Left-justify to Q1.31; 8-bit samples are offset binary, so the top bit flips.
  always_comb begin
    case (nb)
      3'd1:    norm = {~raw_next[7], raw_next[6:0], 24'd0};
      3'd2:    norm = {raw_next[15:0], 16'd0};
      3'd3:    norm = {raw_next[23:0], 8'd0};
      default: norm = raw_next;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_zero || cmd_i.load_sample) begin
      out_channel_o  <= j_q;
      sample_value_o <= cmd_i.load_sample ? norm : 32'd0;
      out_status_o   <= unsupported;
      frame_last_o   <= status_o.j_last;
    end
  end

endmodule

// ===== sv/pcm_frame_unpacker.sv =====
// Collection takes one word per cycle; the word that completes a frame starts emission.
// Each result then passes through pick and send for a zero sample, else through pick,
// one store read per byte, merge and send; no word is taken during emission.
// The frame store has a single read port, so a sample's bytes are read one after another.
// Reset sets the registers to their defaults and clears the byte position and frame
// count; the frame store is not cleared.
module pcm_frame_unpacker import pfu_pkg::*; #(
  parameter int unsigned MAX_CHANNELS     = DEF_MAX_CHANNELS,
  parameter int unsigned MAX_SAMPLE_BYTES = DEF_MAX_SAMPLE_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // [7:0] data_byte
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [39:0]       m_axis_tdata_o,   // [2:0] out_channel, [34:3] sample_value
  output logic              m_axis_tlast_o,   // frame_last
  output logic              m_axis_tuser_o,   // [0] status
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t        cfg;
  cmd_t        cmd;
  status_t     status;
  logic [2:0]  out_channel;
  logic [31:0] sample_value;

  pfu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfu_dp #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .data_byte_i    (s_axis_tdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_channel_o  (out_channel),
    .sample_value_o (sample_value),
    .out_status_o   (m_axis_tuser_o),
    .frame_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'd0, sample_value, out_channel};

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of pcm_frame_unpacker: byte stream in, per-channel samples out.
// It predicts every sample from its own model of the frame store and registers.
// Depends on pfu_pkg and the pcm_frame_unpacker RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pfu_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES  = 60;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_ITEMS    = 56;
  localparam int unsigned RANDOM_PHASES  = 8;

  typedef struct packed {
    logic [2:0]  chan;
    logic [31:0] value;
    logic        status;
    logic        last;
  } sample_t;

  class frame_deinterleaver;
    cfg_t          cfg;
    logic [7:0]    frame_store [32];
    int unsigned   byte_pos;
    logic [31:0]   frames_done;
    sample_t       pending_samples [$];
    int unsigned   mismatches;

    function new();
      cfg.sample_bytes  = RST_SAMPLE_BYTES;
      cfg.channel_count = RST_CHANNEL_COUNT;
      cfg.big_endian    = RST_BIG_ENDIAN;
      cfg.frame_limit   = RST_FRAME_LIMIT;
      cfg.channel_order = RST_CHANNEL_ORDER;
      foreach (frame_store[i]) frame_store[i] = 8'h00;
      byte_pos    = 0;
      frames_done = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] data);
      case (idx)
        REG_SAMPLE_BYTES:  cfg.sample_bytes  = data[2:0];
        REG_CHANNEL_COUNT: cfg.channel_count = data[3:0];
        REG_BIG_ENDIAN:    cfg.big_endian    = data[0];
        REG_FRAME_LIMIT:   cfg.frame_limit   = data;
        REG_CHANNEL_ORDER: cfg.channel_order = data[23:0];
        default: ;
      endcase
    endfunction

    function int unsigned bytes_per_sample();
      if (cfg.sample_bytes == 0) return 1;
      if (cfg.sample_bytes > DEF_MAX_SAMPLE_BYTES) return DEF_MAX_SAMPLE_BYTES;
      return cfg.sample_bytes;
    endfunction

    function int unsigned channels();
      if (cfg.channel_count == 0) return 1;
      if (cfg.channel_count > DEF_MAX_CHANNELS) return DEF_MAX_CHANNELS;
      return cfg.channel_count;
    endfunction

    function logic [31:0] assemble(int unsigned src, int unsigned nb);
      logic [31:0] raw;
      logic [7:0]  b;
      raw = '0;
      for (int unsigned k = 0; k < nb; k++) begin
        b = frame_store[(src * nb + k) % 32];
        if (cfg.big_endian) raw = (raw << 8) | 32'(b);
        else raw = raw | (32'(b) << (8 * k));
      end
      // Eight-bit samples are offset binary: flipping the top bit recentres them.
      if (nb == 1) return {~raw[7], raw[6:0], 24'h000000};
      return raw << (32 - 8 * nb);
    endfunction

    // Returns 0 when the word is dropped because the frame limit has been reached.
    function bit note_byte(logic [7:0] data);
      int unsigned nb;
      int unsigned nc;
      int unsigned src;
      bit          unsupported;
      sample_t     s;
      nb = bytes_per_sample();
      nc = channels();
      if (cfg.frame_limit != 0 && frames_done >= cfg.frame_limit) return 0;
      frame_store[byte_pos % 32] = data;
      if (byte_pos + 1 < nb * nc) begin
        byte_pos = (byte_pos + 1) % 32;
        return 1;
      end
      byte_pos = 0;
      if (cfg.frame_limit != 0) frames_done++;
      unsupported = cfg.big_endian && nb >= 3;
      for (int unsigned j = 0; j < nc; j++) begin
        src      = cfg.channel_order[3*j +: 3];
        s.chan   = 3'(j);
        s.value  = (!unsupported && src < nc) ? assemble(src, nb) : 32'h0;
        s.status = unsupported;
        s.last   = (j + 1 == nc);
        pending_samples.push_back(s);
      end
      return 1;
    endfunction

    function void check_sample(logic [39:0] data, logic last, logic status);
      sample_t want;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample, actual chan %0d value %h status %0b last %0b",
                 $time, data[2:0], data[34:3], status, last);
        mismatches++;
        return;
      end
      want = pending_samples.pop_front();
      if (data[2:0] !== want.chan) begin
        $display("%0t: out_channel expected %0d actual %0d", $time, want.chan, data[2:0]);
        mismatches++;
      end
      if (data[34:3] !== want.value) begin
        $display("%0t: sample_value expected %h actual %h", $time, want.value, data[34:3]);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0b actual %0b", $time, want.status, status);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i  = 8'h00;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [39:0]       m_axis_tdata_o;
  logic              m_axis_tlast_o;
  logic              m_axis_tuser_o;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [CFG_AW-1:0] paddr           = '0;
  logic [31:0]       pwdata          = '0;
  logic [31:0]       prdata;
  logic              pready;

  frame_deinterleaver board = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned idle_cycles    = 0;

  pcm_frame_unpacker i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sample sink: checks each word taken and decides the next cycle's tready.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i)
      board.check_sample(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pcm_frame_unpacker: mismatch");
      $finish;
    end
  end

  // The bus returns to idle for one cycle after each write.
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [2:0] nbytes, input logic [3:0] nchan,
                           input logic big, input logic [31:0] limit,
                           input logic [23:0] order);
    apb_write(REG_SAMPLE_BYTES, 32'(nbytes));
    apb_write(REG_CHANNEL_COUNT, 32'(nchan));
    apb_write(REG_BIG_ENDIAN, 32'(big));
    apb_write(REG_FRAME_LIMIT, limit);
    apb_write(REG_CHANNEL_ORDER, 32'(order));
  endtask

  // Returns whether the block kept the word rather than dropping it.
  task automatic send_byte(input logic [7:0] data, output bit kept);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    kept = board.note_byte(data);
  endtask

  task automatic send_bytes(input logic [7:0] data []);
    bit kept;
    foreach (data[i]) send_byte(data[i], kept);
  endtask

  // Stops offering words until every predicted sample has left the block.
  task automatic drain(input int unsigned extra);
    s_axis_tvalid_i <= 1'b0;
    while (board.pending_samples.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    logic [2:0]  nbytes;
    logic [3:0]  nchan;
    logic [31:0] limit;
    logic [23:0] order;
    int unsigned kept_count;
    int unsigned dropped;
    bit          kept;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Defaults first: two 16-bit channels, little-endian.
    send_bytes('{8'h00, 8'h80, 8'hFF, 8'h7F});
    drain(SETTLE_CYCLES);
    // Eight-bit samples with one permutation entry beyond the channel count.
    configure(3'd1, 4'd3, 1'b0, 32'd0, 24'h00003A);
    send_bytes('{8'h00, 8'hFF, 8'h80});
    drain(SETTLE_CYCLES);
    // Big-endian 24 and 32-bit frames are flagged as unsupported.
    configure(3'd3, 4'd1, 1'b1, 32'd0, 24'h000000);
    send_bytes('{8'h12, 8'h34, 8'h56});
    drain(SETTLE_CYCLES);
    configure(3'd4, 4'd1, 1'b1, 32'd0, 24'h000000);
    send_bytes('{8'h80, 8'h00, 8'h00, 8'h01});
    drain(SETTLE_CYCLES);
    // A zero sample size and a zero channel count both act as one.
    configure(3'd0, 4'd0, 1'b1, 32'd0, 24'h000000);
    send_bytes('{8'h7F, 8'h81});
    drain(SETTLE_CYCLES);
    // An oversized sample size acts as four bytes.
    configure(3'd5, 4'd1, 1'b0, 32'd0, 24'h000000);
    send_bytes('{8'h00, 8'h00, 8'h00, 8'h80});
    drain(SETTLE_CYCLES);
    // One more frame is allowed, then words are dropped.
    configure(3'd2, 4'd1, 1'b1, board.frames_done + 32'd1, 24'h000000);
    send_bytes('{8'hFF, 8'hFE, 8'h01, 8'h02});
    drain(SETTLE_CYCLES);
    // The sample size shrinks while a frame is half collected.
    configure(3'd2, 4'd1, 1'b0, 32'd0, 24'h000000);
    send_bytes('{8'hA5});
    drain(SETTLE_CYCLES);
    configure(3'd1, 4'd1, 1'b0, 32'd0, 24'h000000);
    send_bytes('{8'h3C});
    drain(SETTLE_CYCLES);

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      nbytes = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
      case ($urandom_range(9))
        0:       nchan = 4'($urandom_range(15));
        1, 2:    nchan = 4'($urandom_range(5, 8));
        default: nchan = 4'($urandom_range(1, 4));
      endcase
      case ($urandom_range(5))
        3:       limit = 32'hFFFF_FFFF;
        4, 5:    limit = board.frames_done + 32'($urandom_range(1, 6));
        default: limit = 32'd0;
      endcase
      order = 24'($urandom);
      if ($urandom_range(4) == 0) order = ($urandom_range(1) != 0) ? 24'hFFFFFF : 24'h000000;
      if (phase == 0) limit = 32'hFFFF_FFFF;
      if (phase == 1) order = 24'h000000;
      if (phase == 4) order = 24'hFFFFFF;
      // The largest frame: eight channels of four bytes fill the whole store.
      if (phase == 3) begin
        nbytes = 3'd4;
        nchan  = 4'd8;
        limit  = 32'd0;
      end
      configure(nbytes, nchan, 1'($urandom_range(1)), limit, order);

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      // The sink holds off for a long stretch while words keep coming.
      if (phase == 2) hold_request = HOLD_CYCLES;

      kept_count = 0;
      dropped    = 0;
      while (kept_count < PHASE_ITEMS && dropped < 8) begin
        send_byte(pick_byte(), kept);
        if (kept) kept_count++;
        else dropped++;
      end
      drain(SETTLE_CYCLES);
    end

    drain(DRAIN_CYCLES);
    if (board.mismatches == 0 && board.pending_samples.size() == 0) begin
      $display("pcm_frame_unpacker: match");
    end else begin
      $display("pcm_frame_unpacker: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pfu_pkg.sv
sv/pfu_regs.sv
sv/pfu_ctrl.sv
sv/pfu_dp.sv
sv/pcm_frame_unpacker.sv
test/testbench.sv
